### rtl/core/jahg_pkg.sv
// jahg_pkg: shared widths, register indexes, reset values, sequencer
// states and lane control structs for the joint admittance hold/guide block.
// No dependencies.
package jahg_pkg;

  localparam int JOINTS_DEF = 6;

  localparam int TQ_W    = 16;  // Q8.8 torque
  localparam int POS_W   = 20;  // Q4.16 position
  localparam int VEL_W   = 16;  // Q4.12 velocity
  localparam int GAIN_W  = 16;  // Q0.16 gain
  localparam int LIM_W   = 15;  // clamp and threshold registers
  localparam int STEP_W  = 16;  // Q0.16 period
  localparam int PEAK_W  = 16;
  localparam int IDX_W   = 3;
  localparam int PROD_W  = 32;
  localparam int FRAC_SH = 12;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 48;
  localparam int GAIN_SLOTS = 3;  // gains per 48-bit register

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_SH - 1);

  localparam logic [CFG_AW-1:0] REG_GAINS_LO  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_GAINS_HI  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MAX_VEL   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_HOLD_THR  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_GUIDE_THR = 3'd4;
  localparam logic [CFG_AW-1:0] REG_STEP_TIME = 3'd5;

  localparam logic [CFG_DW-1:0] GAINS_RST     = 48'd14074822593741;
  localparam logic [LIM_W-1:0]  MAX_VEL_RST   = 15'd2048;
  localparam logic [LIM_W-1:0]  HOLD_THR_RST  = 15'd128;
  localparam logic [LIM_W-1:0]  GUIDE_THR_RST = 15'd256;
  localparam logic [STEP_W-1:0] STEP_TIME_RST = 16'd66;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLAMP,
    S_SUM,
    S_OUT
  } seq_state_t;

  // sequencer strobes shared by lanes and the merge stage
  typedef struct packed {
    logic load;
    logic clamp;
    logic sum;
  } seq_ctl_t;

  typedef struct packed {
    seq_ctl_t seq;
    logic     latch;
    logic     hold;
  } lane_ctl_t;

endpackage

### rtl/core/jahg_in_if.sv
// jahg_in_if: input channel, one control tick of joint torques and positions.
// Depends on jahg_pkg.
interface jahg_in_if #(
  parameter int JOINTS = jahg_pkg::JOINTS_DEF
);
  logic                                   valid;
  logic                                   ready;
  logic [JOINTS-1:0][jahg_pkg::TQ_W-1:0]  torque;
  logic [JOINTS-1:0][jahg_pkg::POS_W-1:0] position;

  modport source (output valid, output torque, output position, input ready);
  modport sink (input valid, input torque, input position, output ready);
endinterface

### rtl/core/jahg_out_if.sv
// jahg_out_if: result channel, one joint's velocity and target per transfer.
// Depends on jahg_pkg.
interface jahg_out_if;
  logic                              valid;
  logic                              ready;
  logic [jahg_pkg::IDX_W-1:0]        joint_index;
  logic signed [jahg_pkg::VEL_W-1:0] velocity;
  logic signed [jahg_pkg::POS_W-1:0] target;
  logic                              holding;
  logic [jahg_pkg::PEAK_W-1:0]       peak_torque;
  logic                              last;

  modport source (output valid, output joint_index, output velocity, output target,
                  output holding, output peak_torque, output last, input ready);
  modport sink (input valid, input joint_index, input velocity, input target,
                input holding, input peak_torque, input last, output ready);
endinterface

### rtl/core/jahg_lane.sv
// jahg_lane: one joint's admittance datapath: gain multiply, round and clamp,
// period multiply, target add with saturation, and the latched hold pose.
// Depends on jahg_pkg.
module jahg_lane (
  input  logic                                clk,
  input  jahg_pkg::lane_ctl_t                 ctl,
  input  logic        [jahg_pkg::TQ_W-1:0]    torque,
  input  logic        [jahg_pkg::POS_W-1:0]   position,
  input  logic        [jahg_pkg::GAIN_W-1:0]  gain,
  input  logic        [jahg_pkg::LIM_W-1:0]   max_vel,
  input  logic        [jahg_pkg::STEP_W-1:0]  step_time,
  output logic        [jahg_pkg::PEAK_W-1:0]  mag,
  output logic signed [jahg_pkg::VEL_W-1:0]   vel,
  output logic signed [jahg_pkg::POS_W-1:0]   tgt
);
  localparam int PW = jahg_pkg::POS_W;
  localparam int LW = jahg_pkg::LIM_W;
  localparam int RW = jahg_pkg::PROD_W - jahg_pkg::FRAC_SH;

  logic                              neg_r;
  logic [PW-1:0]                     pos_r;
  logic [jahg_pkg::PROD_W-1:0]       prod_r;
  logic [LW-1:0]                     vm_r;
  logic [jahg_pkg::PROD_W-1:0]       dprod_r;
  logic [PW-1:0]                     hold_pose_r;
  logic signed [jahg_pkg::VEL_W-1:0] vel_r;
  logic signed [PW-1:0]              tgt_r;

  logic [jahg_pkg::PROD_W-1:0] prod;
  logic [jahg_pkg::PROD_W-1:0] vel_rnd;
  logic [RW-1:0]               vmag;
  logic [LW-1:0]               vclamp;
  logic [jahg_pkg::PROD_W-1:0] dprod;
  logic [jahg_pkg::PROD_W-1:0] d_rnd;
  logic [PW:0]                 pos_ext;
  logic [PW:0]                 d_ext;
  logic [PW:0]                 sum;
  logic [PW-1:0]               tgt_sat;
  logic [jahg_pkg::VEL_W-1:0]  vm_ext;
  logic [jahg_pkg::VEL_W-1:0]  vel_s;

  assign mag  = torque[jahg_pkg::TQ_W-1] ? jahg_pkg::PEAK_W'(-torque) : torque;
  assign prod = mag * gain;

  // Q8.24 -> Q4.12, half away from zero on the magnitude
  assign vel_rnd = prod_r + jahg_pkg::ROUND_HALF;
  assign vmag    = vel_rnd[jahg_pkg::PROD_W-1:jahg_pkg::FRAC_SH];
  assign vclamp  = (vmag > RW'(max_vel)) ? max_vel : vmag[LW-1:0];
  assign dprod   = vclamp * step_time;

  assign d_rnd   = dprod_r + jahg_pkg::ROUND_HALF;
  assign pos_ext = {pos_r[PW-1], pos_r};
  assign d_ext   = (PW+1)'(d_rnd[jahg_pkg::PROD_W-1:jahg_pkg::FRAC_SH]);
  assign sum     = neg_r ? (pos_ext - d_ext) : (pos_ext + d_ext);

  always_comb begin
    if (sum[PW] != sum[PW-1]) begin
      tgt_sat = sum[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
    end else begin
      tgt_sat = sum[PW-1:0];
    end
  end

  assign vm_ext = jahg_pkg::VEL_W'(vm_r);
  assign vel_s  = neg_r ? (-vm_ext) : vm_ext;

  always_ff @(posedge clk) begin
    if (ctl.seq.load) begin
      neg_r  <= torque[jahg_pkg::TQ_W-1];
      pos_r  <= position;
      prod_r <= prod;
    end
    if (ctl.seq.clamp) begin
      vm_r    <= vclamp;
      dprod_r <= dprod;
    end
    if (ctl.latch) begin
      hold_pose_r <= pos_r;
    end
    if (ctl.seq.sum) begin
      vel_r <= ctl.hold ? '0 : $signed(vel_s);
      tgt_r <= ctl.hold ? $signed(hold_pose_r) : $signed(tgt_sat);
    end
  end

  assign vel = vel_r;
  assign tgt = tgt_r;

endmodule

### rtl/core/jahg_merge.sv
// jahg_merge: peak absolute torque over all lanes and the hold/guide
// hysteresis switch, including the hold-pose latch strobe.
// Depends on jahg_pkg.
module jahg_merge #(
  parameter int JOINTS = jahg_pkg::JOINTS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  jahg_pkg::seq_ctl_t                      seq,
  input  logic [JOINTS-1:0][jahg_pkg::PEAK_W-1:0] mags,
  input  logic [jahg_pkg::LIM_W-1:0]              hold_thr,
  input  logic [jahg_pkg::LIM_W-1:0]              guide_thr,
  output logic [jahg_pkg::PEAK_W-1:0]             peak,
  output logic                                    hold,
  output logic                                    latch
);
  localparam int KW = jahg_pkg::PEAK_W;

  logic [KW-1:0] peak_r;
  logic [KW-1:0] peak_nxt;
  logic          hold_r;
  logic          hold_nxt;
  logic          latched_r;
  logic          below_hold;
  logic          above_guide;

  always_comb begin
    peak_nxt = mags[0];
    for (int j = 1; j < JOINTS; j++) begin
      if (mags[j] > peak_nxt) begin
        peak_nxt = mags[j];
      end
    end
  end

  assign below_hold  = peak_r < KW'(hold_thr);
  assign above_guide = peak_r > KW'(guide_thr);
  assign hold_nxt    = hold_r ? !above_guide : below_hold;

  // first tick after reset always takes the pose
  assign latch = seq.clamp && (!latched_r || (!hold_r && below_hold));

  always_ff @(posedge clk) begin
    if (seq.load) begin
      peak_r <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r    <= 1'b1;
      latched_r <= 1'b0;
    end else if (seq.clamp) begin
      hold_r    <= hold_nxt;
      latched_r <= 1'b1;
    end
  end

  assign peak = peak_r;
  assign hold = hold_r;

endmodule

### rtl/core/joint_admittance_hold_guide.sv
// joint_admittance_hold_guide: top level with configuration registers,
// tick sequencer and per-joint result serializer.
// Depends on jahg_pkg, jahg_in_if, jahg_out_if, jahg_lane, jahg_merge.
//
// Usage: in_if carries one control tick (JOINTS torques and positions); out_if
// returns JOINTS results, joint 0 first, last set on the final joint. Each
// result holds the hysteresis mode, the tick's peak torque, the velocity and
// the position target. Configuration is written through cfg_we/cfg_index/
// cfg_data; the user writes it only while no tick is in flight, which the
// block itself does not enforce. Unknown indexes are dropped.
// The gain multiply is registered at the input transfer, then the clamp and
// period multiply, then the add and saturate; results then follow, one result
// per cycle while out_if.ready stays high. A new tick is taken in the same
// cycle as the transfer of the previous tick's last result; each tick passes
// through the clamp and sum states, then the output state for its JOINTS results.
// A stall on out_if holds the current result and keeps in_if.ready low.
// Reset returns to idle with mode HOLD and no pose latched; the first tick
// latches the hold pose. Configuration resets to its default values.
module joint_admittance_hold_guide #(
  parameter int JOINTS = jahg_pkg::JOINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  jahg_in_if.sink                       in_if,
  jahg_out_if.source                    out_if,
  input  logic                          cfg_we,
  input  logic [jahg_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [jahg_pkg::CFG_DW-1:0]   cfg_data
);
  localparam int IW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int GW = jahg_pkg::GAIN_W;
  localparam int LW = jahg_pkg::LIM_W;

  logic [jahg_pkg::CFG_DW-1:0] gains_lo_r;
  logic [jahg_pkg::CFG_DW-1:0] gains_hi_r;
  logic [LW-1:0]               max_vel_r;
  logic [LW-1:0]               hold_thr_r;
  logic [LW-1:0]               guide_thr_r;
  logic [jahg_pkg::STEP_W-1:0] step_time_r;

  jahg_pkg::seq_state_t state_r, state_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic                 in_ready;
  logic                 in_accept;
  logic                 out_valid;
  logic                 idx_last;

  jahg_pkg::seq_ctl_t  seq;
  jahg_pkg::lane_ctl_t lane_ctl;
  logic                hold;
  logic                latch;
  logic [jahg_pkg::PEAK_W-1:0] peak;

  logic [JOINTS-1:0][jahg_pkg::PEAK_W-1:0] mags;
  logic [JOINTS-1:0][GW-1:0]               gains;
  logic signed [jahg_pkg::VEL_W-1:0]       vel [JOINTS];
  logic signed [jahg_pkg::POS_W-1:0]       tgt [JOINTS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_lo_r  <= jahg_pkg::GAINS_RST;
      gains_hi_r  <= jahg_pkg::GAINS_RST;
      max_vel_r   <= jahg_pkg::MAX_VEL_RST;
      hold_thr_r  <= jahg_pkg::HOLD_THR_RST;
      guide_thr_r <= jahg_pkg::GUIDE_THR_RST;
      step_time_r <= jahg_pkg::STEP_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        jahg_pkg::REG_GAINS_LO:  gains_lo_r  <= cfg_data;
        jahg_pkg::REG_GAINS_HI:  gains_hi_r  <= cfg_data;
        jahg_pkg::REG_MAX_VEL:   max_vel_r   <= cfg_data[LW-1:0];
        jahg_pkg::REG_HOLD_THR:  hold_thr_r  <= cfg_data[LW-1:0];
        jahg_pkg::REG_GUIDE_THR: guide_thr_r <= cfg_data[LW-1:0];
        jahg_pkg::REG_STEP_TIME: step_time_r <= cfg_data[jahg_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  assign idx_last  = (idx_r == IW'(JOINTS - 1));
  assign in_accept = in_if.valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      jahg_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_if.valid) begin
          state_nxt = jahg_pkg::S_CLAMP;
        end
      end
      jahg_pkg::S_CLAMP: begin
        state_nxt = jahg_pkg::S_SUM;
      end
      jahg_pkg::S_SUM: begin
        state_nxt = jahg_pkg::S_OUT;
        idx_nxt   = '0;
      end
      jahg_pkg::S_OUT: begin
        out_valid = 1'b1;
        in_ready  = out_if.ready && idx_last;
        if (out_if.ready) begin
          if (idx_last) begin
            state_nxt = in_if.valid ? jahg_pkg::S_CLAMP : jahg_pkg::S_IDLE;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end
      default: begin
        state_nxt = jahg_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jahg_pkg::S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign seq.load  = in_accept;
  assign seq.clamp = (state_r == jahg_pkg::S_CLAMP);
  assign seq.sum   = (state_r == jahg_pkg::S_SUM);

  assign lane_ctl.seq   = seq;
  assign lane_ctl.latch = latch;
  assign lane_ctl.hold  = hold;

  jahg_merge #(
    .JOINTS(JOINTS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .seq       (seq),
    .mags      (mags),
    .hold_thr  (hold_thr_r),
    .guide_thr (guide_thr_r),
    .peak      (peak),
    .hold      (hold),
    .latch     (latch)
  );

  for (genvar j = 0; j < JOINTS; j++) begin : g_lane
    // joints beyond the two gain registers run with zero gain
    if (j < jahg_pkg::GAIN_SLOTS) begin : g_lo
      assign gains[j] = gains_lo_r[GW*j +: GW];
    end else if (j < 2 * jahg_pkg::GAIN_SLOTS) begin : g_hi
      assign gains[j] = gains_hi_r[GW*(j - jahg_pkg::GAIN_SLOTS) +: GW];
    end else begin : g_none
      assign gains[j] = '0;
    end

    jahg_lane u_lane (
      .clk       (clk),
      .ctl       (lane_ctl),
      .torque    (in_if.torque[j]),
      .position  (in_if.position[j]),
      .gain      (gains[j]),
      .max_vel   (max_vel_r),
      .step_time (step_time_r),
      .mag       (mags[j]),
      .vel       (vel[j]),
      .tgt       (tgt[j])
    );
  end

  assign in_if.ready        = in_ready;
  assign out_if.valid       = out_valid;
  assign out_if.joint_index = jahg_pkg::IDX_W'(idx_r);
  assign out_if.velocity    = vel[idx_r];
  assign out_if.target      = tgt[idx_r];
  assign out_if.holding     = hold;
  assign out_if.peak_torque = peak;
  assign out_if.last        = idx_last;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == jahg_pkg::S_CLAMP))
    else $error("transfer in did not start the clamp step");

  a_stall_holds_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_if.ready) |=> ($stable(idx_r) && out_valid))
    else $error("joint index moved during an output stall");

  a_hold_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_if.holding) |-> (out_if.velocity == '0))
    else $error("nonzero velocity while holding");

  a_vel_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_if.holding) |->
      ((out_if.velocity <= $signed({1'b0, max_vel_r})) &&
       (out_if.velocity >= -$signed({1'b0, max_vel_r}))))
    else $error("velocity outside the clamp");

  a_no_accept_midtick: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == jahg_pkg::S_CLAMP) || (state_r == jahg_pkg::S_SUM)) |-> !in_ready)
    else $error("input ready while a tick is being computed");

endmodule

### sim/joint_admittance_hold_guide_test.sv
// Self-checking bench for joint_admittance_hold_guide: directed ticks on the
// hold/guide switch, then randomized ticks under several register settings.
// Depends on jahg_pkg, jahg_in_if, jahg_out_if and the block itself.
module joint_admittance_hold_guide_test;
  import jahg_pkg::*;

  localparam int JN          = JOINTS_DEF;
  localparam int GAP_MAX     = 18;
  localparam int SETTLE      = 12;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_TICKS = 16;
  localparam int POS_HI      = (1 << (POS_W - 1)) - 1;
  localparam int POS_LO      = -(1 << (POS_W - 1));

  // indexes the block has no register behind
  localparam logic [CFG_AW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_AW-1:0] REG_SPARE_B = 3'd7;

  typedef logic [JN-1:0][TQ_W-1:0]  torque_vec_t;
  typedef logic [JN-1:0][POS_W-1:0] position_vec_t;

  typedef struct packed {
    logic [IDX_W-1:0]        joint;
    logic signed [VEL_W-1:0] velocity;
    logic signed [POS_W-1:0] target;
    logic                    holding;
    logic [PEAK_W-1:0]       peak;
    logic                    last;
  } joint_result_t;

  class joint_result_board;
    logic [CFG_DW-1:0]       gains_lo, gains_hi;
    logic [LIM_W-1:0]        vel_limit, hold_thr, guide_thr;
    logic [STEP_W-1:0]       period;
    bit                      holding, pose_valid;
    longint                  hold_pose[JN];
    joint_result_t           pending_results[$];
    int                      errors;

    function new();
      gains_lo   = GAINS_RST;
      gains_hi   = GAINS_RST;
      vel_limit  = MAX_VEL_RST;
      hold_thr   = HOLD_THR_RST;
      guide_thr  = GUIDE_THR_RST;
      period     = STEP_TIME_RST;
      holding    = 1'b1;
      pose_valid = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        REG_GAINS_LO:  gains_lo  = data;
        REG_GAINS_HI:  gains_hi  = data;
        REG_MAX_VEL:   vel_limit = data[LIM_W-1:0];
        REG_HOLD_THR:  hold_thr  = data[LIM_W-1:0];
        REG_GUIDE_THR: guide_thr = data[LIM_W-1:0];
        REG_STEP_TIME: period    = data[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    // signed value times unsigned factor, >> FRAC_SH, rounded half away from zero
    function longint round_scale(longint a, longint f);
      longint mag, p;
      mag = (a < 0) ? -a : a;
      p = (mag * f + (longint'(1) << (FRAC_SH - 1))) >>> FRAC_SH;
      return (a < 0) ? -p : p;
    endfunction

    function void note_tick(torque_vec_t tq, position_vec_t ps);
      longint t[JN];
      longint p[JN];
      longint peak, mag, gain, vel, tgt, lim;
      joint_result_t r;
      peak = 0;
      for (int j = 0; j < JN; j++) begin
        t[j] = longint'($signed(tq[j]));
        p[j] = longint'($signed(ps[j]));
        mag = (t[j] < 0) ? -t[j] : t[j];
        if (mag > peak) peak = mag;
      end
      if (!pose_valid) begin
        for (int j = 0; j < JN; j++) hold_pose[j] = p[j];
        pose_valid = 1'b1;
      end
      if (holding) begin
        if (peak > longint'(guide_thr)) holding = 1'b0;
      end else if (peak < longint'(hold_thr)) begin
        holding = 1'b1;
        for (int j = 0; j < JN; j++) hold_pose[j] = p[j];
      end
      lim = longint'(vel_limit);
      for (int j = 0; j < JN; j++) begin
        vel = 0;
        if (holding) begin
          tgt = hold_pose[j];
        end else begin
          if (j < GAIN_SLOTS) gain = longint'(gains_lo[GAIN_W*j +: GAIN_W]);
          else if (j < 2 * GAIN_SLOTS)
            gain = longint'(gains_hi[GAIN_W*(j-GAIN_SLOTS) +: GAIN_W]);
          else gain = 0;
          vel = round_scale(t[j], gain);
          if (vel > lim) vel = lim;
          if (vel < -lim) vel = -lim;
          tgt = p[j] + round_scale(vel, longint'(period));
          if (tgt > POS_HI) tgt = POS_HI;
          if (tgt < POS_LO) tgt = POS_LO;
        end
        r.joint    = IDX_W'(j);
        r.velocity = VEL_W'(vel);
        r.target   = POS_W'(tgt);
        r.holding  = holding;
        r.peak     = PEAK_W'(peak);
        r.last     = (j == JN - 1);
        pending_results = {pending_results, r};
      end
    endfunction

    function void check_result(joint_result_t got);
      joint_result_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: joint_index %0d", got.joint);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.joint !== want.joint) begin
        $error("joint_index: expected %0d, got %0d", want.joint, got.joint);
        errors++;
      end
      if (got.velocity !== want.velocity) begin
        $error("velocity: expected %0d, got %0d", want.velocity, got.velocity);
        errors++;
      end
      if (got.target !== want.target) begin
        $error("target: expected %0d, got %0d", want.target, got.target);
        errors++;
      end
      if (got.holding !== want.holding) begin
        $error("holding: expected %0b, got %0b", want.holding, got.holding);
        errors++;
      end
      if (got.peak !== want.peak) begin
        $error("peak_torque: expected %0d, got %0d", want.peak, got.peak);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  joint_result_board results;
  int  cycles = 0;
  int  hold_request = 0;
  bit  send_fast = 1'b0;
  bit  recv_fast = 1'b0;
  int  torque_level = 2;

  jahg_in_if #(.JOINTS(JN)) in_ch ();
  jahg_out_if out_ch ();

  joint_admittance_hold_guide #(.JOINTS(JN)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // monitors sample pre-edge values
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      results.note_tick(in_ch.torque, in_ch.position);
  end

  always @(posedge clk) begin
    joint_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.joint    = out_ch.joint_index;
      got.velocity = out_ch.velocity;
      got.target   = out_ch.target;
      got.holding  = out_ch.holding;
      got.peak     = out_ch.peak_torque;
      got.last     = out_ch.last;
      results.check_result(got);
    end
  end

  // receiver: random stall before each result, or one long hold-off on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = recv_fast ? 0 : $urandom_range(0, GAP_MAX);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  // leaves valid high after the transfer; drain, or the next call when it waits a gap, lowers it
  task automatic send_tick(torque_vec_t tq, position_vec_t ps);
    int gap;
    gap = send_fast ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.torque   <= tq;
    in_ch.position <= ps;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // one edge first so the input monitor has noted the last transfer
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    results.write_reg(idx, data);
  endtask

  // junk above the register width must be dropped by the block
  task automatic configure(logic [CFG_DW-1:0] gl, logic [CFG_DW-1:0] gh,
                           logic [LIM_W-1:0] vmax, logic [LIM_W-1:0] hthr,
                           logic [LIM_W-1:0] gthr, logic [STEP_W-1:0] dt);
    logic [CFG_DW-1:0] junk;
    junk = CFG_DW'({$urandom, $urandom});
    write_reg(REG_GAINS_LO, gl);
    write_reg(REG_GAINS_HI, gh);
    write_reg(REG_MAX_VEL, {junk[CFG_DW-1:LIM_W], vmax});
    write_reg(REG_HOLD_THR, {junk[CFG_DW-2:LIM_W-1], hthr});
    write_reg(REG_GUIDE_THR, {junk[CFG_DW-3:LIM_W-2], gthr});
    write_reg(REG_STEP_TIME, {junk[CFG_DW-1:STEP_W], dt});
    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
              CFG_DW'({$urandom, $urandom}));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic position_vec_t random_positions();
    position_vec_t ps;
    for (int j = 0; j < JN; j++) begin
      case ($urandom_range(0, 7))
        0: ps[j] = POS_W'(POS_HI);
        1: ps[j] = POS_W'(POS_LO);
        default: ps[j] = POS_W'($urandom);
      endcase
    end
    return ps;
  endfunction

  // torque level sticks for a few ticks so hold and guide runs form
  function automatic torque_vec_t random_torques();
    torque_vec_t tq;
    int lim, mag;
    if ($urandom_range(0, 3) == 0) torque_level = $urandom_range(0, 3);
    case (torque_level)
      0: lim = int'(results.hold_thr);
      1: lim = int'(results.guide_thr) + 64;
      default: lim = 8191;
    endcase
    if (lim > 32767) lim = 32767;
    for (int j = 0; j < JN; j++) begin
      if (torque_level == 3) begin
        tq[j] = TQ_W'($urandom);
      end else begin
        mag = $urandom_range(0, lim);
        tq[j] = $urandom_range(0, 1) ? TQ_W'(-mag) : TQ_W'(mag);
      end
    end
    return tq;
  endfunction

  // every joint gets fill, except one that carries the peak
  function automatic torque_vec_t peak_on(int joint, int peak_val, int fill);
    torque_vec_t tq;
    for (int j = 0; j < JN; j++) tq[j] = TQ_W'(fill);
    tq[joint] = TQ_W'(peak_val);
    return tq;
  endfunction

  initial begin
    position_vec_t ps;
    torque_vec_t   tq;
    logic [CFG_DW-1:0] gl, gh;
    results = new();
    in_ch.valid    = 1'b0;
    in_ch.torque   = '0;
    in_ch.position = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: first tick latches the pose, then walk the hysteresis edges
    for (int j = 0; j < JN; j++) ps[j] = (j % 2) ? POS_W'(POS_HI) : POS_W'(POS_LO);
    send_tick('0, ps);
    send_tick(peak_on(0, 256, -256), random_positions());   // at guide threshold: stay
    send_tick(peak_on(3, 257, 0), random_positions());      // just above: guide
    tq[0] = TQ_W'(32767);
    tq[1] = TQ_W'(-32768);
    tq[2] = TQ_W'(1);
    tq[3] = TQ_W'(-1);
    tq[4] = TQ_W'(16384);
    tq[5] = TQ_W'(-16384);
    ps = random_positions();
    ps[0] = POS_W'(POS_HI);
    ps[1] = POS_W'(POS_LO);
    send_tick(tq, ps);
    send_tick(peak_on(2, -128, 5), random_positions());     // at hold threshold: stay
    send_tick(peak_on(4, 127, -3), random_positions());     // below: hold, relatch
    send_tick(peak_on(1, 200, 0), random_positions());      // between: stay in hold
    drain();

    // widest settings: huge velocity, saturating targets
    configure('1, '1, '1, '0, '1, '1);
    send_tick(peak_on(0, 32767, -32767), random_positions());
    for (int j = 0; j < JN; j++) ps[j] = (j % 2) ? POS_W'(POS_HI) : POS_W'(POS_LO);
    for (int j = 0; j < JN; j++) tq[j] = (j % 2) ? TQ_W'(32767) : TQ_W'(-32768);
    send_tick(tq, ps);
    send_tick('0, random_positions());                      // hold threshold 0: stay guide
    for (int j = 0; j < JN; j++) tq[j] = (j % 2) ? TQ_W'(-32768) : TQ_W'(32767);
    send_tick(tq, ps);
    drain();

    // zero gain, zero clamp, zero period, equal thresholds
    configure('0, '0, '0, 15'd1000, 15'd1000, '0);
    send_tick(peak_on(5, -999, 0), random_positions());
    send_tick(peak_on(2, 1000, 0), random_positions());
    send_tick(peak_on(3, -1001, 7), random_positions());
    drain();

    // crossed thresholds: mode flips on every tick
    configure({3{16'h8000}}, {16'h0001, 16'hffff, 16'h1234}, 15'd100, 15'd2000,
              15'd500, 16'h8000);
    send_tick(peak_on(0, 1000, -900), random_positions());
    send_tick(peak_on(1, -1000, 900), random_positions());
    send_tick(peak_on(5, 1000, 0), random_positions());
    send_tick(peak_on(4, -1000, 0), random_positions());
    drain();

    // random phases
    for (int phase = 0; phase < 5; phase++) begin
      gl = CFG_DW'({$urandom, $urandom});
      gh = CFG_DW'({$urandom, $urandom});
      if (phase == 3) begin
        gl = '1;
        gh = '0;
      end
      configure(gl, gh, $urandom_range(0, 3) ? LIM_W'($urandom_range(0, 4096)) : '1,
                LIM_W'($urandom_range(0, 2000)), LIM_W'($urandom_range(0, 3000)),
                STEP_W'($urandom));
      send_fast = (phase == 1) || (phase == 2);
      recv_fast = (phase == 2);
      if (phase == 1) hold_request = LONG_HOLD;
      for (int k = 0; k < PHASE_TICKS; k++) begin
        send_tick(random_torques(), random_positions());
        if ($urandom_range(0, 14) == 0) drain();
      end
      drain();
    end

    if (results.errors == 0 && results.pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
